[rtl/interval_set_overlap_check_macros.svh]
// ============================================================================
// interval_set_overlap_check_macros.svh
// Assertion macros shared by the interval overlap checker RTL.
// ============================================================================
`ifndef INTERVAL_SET_OVERLAP_CHECK_MACROS_SVH
`define INTERVAL_SET_OVERLAP_CHECK_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define ISOC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the following cycle.
`define ISOC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Expression holds at every edge out of reset.
`define ISOC_ASSERT_ALW(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

`endif

[rtl/isoc_pkg.sv]
// ============================================================================
// isoc_pkg
// Word types and token control flags for the interval overlap checker.
// ============================================================================
package isoc_pkg;

    localparam int TIME_FIELD_W  = 16;
    localparam int COUNT_FIELD_W = 7;

    // Input word: one interval
    typedef struct packed {
        logic [TIME_FIELD_W-1:0] start_time;
        logic [TIME_FIELD_W-1:0] end_time;
        logic                    last_meeting;
    } t_in_word;

    // Output word: verdict for one set
    typedef struct packed {
        logic                     all_compatible;
        logic                     set_overflow;
        logic [COUNT_FIELD_W-1:0] meeting_count;
    } t_out_word;

    // Control flags that travel with an interval along the cell chain
    typedef struct packed {
        logic valid;
        logic last;
        logic drop;
        logic hit;
    } t_tok_ctl;

endpackage

[rtl/interval_set_overlap_check.sv]
// ============================================================================
// interval_set_overlap_check
// Overlap check over a set of intervals using a chain of storage cells.
// ============================================================================
// Each accepted interval is given its place in the set and then walks down a
// chain of MAX_MEETINGS cells, one cell per cycle while the chain is not
// stalled; every cell before its own place holds an earlier interval of the
// same set and is compared against it, and the cell at its own place
// captures it. One interval is accepted per cycle while the chain is not
// stalled. The edge that accepts a set's last interval loads the first cell,
// and the output register, which drives o_out_valid, loads from the last
// cell. Intervals beyond
// MAX_MEETINGS in a set are neither stored nor compared and mark the set as
// overflowed. Touching intervals are compatible. The chain only stalls while a
// finished verdict waits in the output register and the next set's last
// interval reaches the chain's end.
// ============================================================================
`include "interval_set_overlap_check_macros.svh"

module interval_set_overlap_check
    import isoc_pkg::*;
#(
    parameter int MAX_MEETINGS = 64,
    parameter int TIME_BITS    = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_word
);

    localparam int TW = (TIME_BITS < TIME_FIELD_W) ? TIME_BITS : TIME_FIELD_W;
    localparam int CW = $clog2(MAX_MEETINGS + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_MEETINGS);

    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic          advance;
    logic          accept;
    logic          full;
    logic [CW-1:0] in_cnt;
    t_tok_ctl      head_ctl;

    t_tok_ctl      chain_ctl   [0:MAX_MEETINGS];
    logic [TW-1:0] chain_start [0:MAX_MEETINGS];
    logic [TW-1:0] chain_end   [0:MAX_MEETINGS];
    logic [CW-1:0] chain_cnt   [0:MAX_MEETINGS];

    assign o_in_ready = advance;
    assign accept     = i_in_valid && advance;

    // Assign the interval its place in the set
    always_comb begin
        full    = (r_count == MAX_CNT);
        in_cnt  = full ? MAX_CNT : r_count + CW'(1);
        n_count = i_in_word.last_meeting ? '0 : in_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (accept) begin
            r_count <= n_count;
        end
    end

    // Head of the chain: accepted word or a bubble
    always_comb begin
        head_ctl.valid = accept;
        head_ctl.last  = i_in_word.last_meeting;
        head_ctl.drop  = full;
        head_ctl.hit   = 1'b0;
    end

    assign chain_ctl[0]   = head_ctl;
    assign chain_start[0] = i_in_word.start_time[TW-1:0];
    assign chain_end[0]   = i_in_word.end_time[TW-1:0];
    assign chain_cnt[0]   = in_cnt;

    // Row of storage cells
    for (genvar k = 0; k < MAX_MEETINGS; k++) begin : g_cell
        isoc_cell #(
            .INDEX (k),
            .TW    (TW),
            .CW    (CW)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_advance (advance),
            .i_ctl     (chain_ctl[k]),
            .i_start   (chain_start[k]),
            .i_end     (chain_end[k]),
            .i_cnt     (chain_cnt[k]),
            .o_ctl     (chain_ctl[k+1]),
            .o_start   (chain_start[k+1]),
            .o_end     (chain_end[k+1]),
            .o_cnt     (chain_cnt[k+1])
        );
    end

    // Verdict collection and output register
    isoc_out #(
        .MAX_MEETINGS (MAX_MEETINGS),
        .CW           (CW)
    ) u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (chain_ctl[MAX_MEETINGS]),
        .i_cnt       (chain_cnt[MAX_MEETINGS]),
        .o_advance   (advance),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

    // Fill count stays within the store and restarts after each set
    `ISOC_ASSERT_ALW(a_count_range, i_clk, i_rst_n, r_count <= MAX_CNT, "fill count beyond store depth")
    `ISOC_ASSERT_NXT(a_count_restart, i_clk, i_rst_n, accept && i_in_word.last_meeting, r_count == '0, "fill count not cleared after last interval")

endmodule

[rtl/isoc_cell.sv]
// ============================================================================
// isoc_cell
// One slot of the interval store. Compares the passing interval against the
// interval held here, or captures it when this slot is its place in the set.
// ============================================================================
`include "interval_set_overlap_check_macros.svh"

module isoc_cell
    import isoc_pkg::*;
#(
    parameter int INDEX = 0,
    parameter int TW    = 16,
    parameter int CW    = 7
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_advance,
    input  t_tok_ctl      i_ctl,
    input  logic [TW-1:0] i_start,
    input  logic [TW-1:0] i_end,
    input  logic [CW-1:0] i_cnt,
    output t_tok_ctl      o_ctl,
    output logic [TW-1:0] o_start,
    output logic [TW-1:0] o_end,
    output logic [CW-1:0] o_cnt
);

    // Count value of an interval whose place is this slot
    localparam logic [CW-1:0] SLOT_CNT = CW'(INDEX + 1);

    t_tok_ctl      r_ctl;
    t_tok_ctl      n_ctl;
    logic [TW-1:0] r_start;
    logic [TW-1:0] r_end;
    logic [CW-1:0] r_cnt;
    logic [TW-1:0] r_slot_start;
    logic [TW-1:0] r_slot_end;
    logic          cmp_en;
    logic          store_en;
    logic          hit;

    // Compare against earlier intervals, capture at own place
    always_comb begin
        cmp_en   = i_ctl.valid && !i_ctl.drop && (i_cnt > SLOT_CNT);
        store_en = i_ctl.valid && !i_ctl.drop && (i_cnt == SLOT_CNT);
        hit      = cmp_en && (i_start < r_slot_end) && (r_slot_start < i_end);
        n_ctl    = i_ctl;
        n_ctl.hit = i_ctl.hit | hit;
    end

    // Hand the word to the next cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_advance) begin
            r_ctl <= n_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_start <= i_start;
            r_end   <= i_end;
            r_cnt   <= i_cnt;
        end
    end

    // Hold the stored interval
    always_ff @(posedge i_clk) begin
        if (i_advance && store_en) begin
            r_slot_start <= i_start;
            r_slot_end   <= i_end;
        end
    end

    assign o_ctl   = r_ctl;
    assign o_start = r_start;
    assign o_end   = r_end;
    assign o_cnt   = r_cnt;

    // A dropped interval must never pick up a conflict
    `ISOC_ASSERT_NXT(a_drop_no_hit, i_clk, i_rst_n, i_advance && i_ctl.valid && i_ctl.drop, r_ctl.hit == $past(i_ctl.hit), "dropped interval gained a conflict")

endmodule

[rtl/isoc_out.sv]
// ============================================================================
// isoc_out
// End of the cell chain: gathers conflict and overflow per set and holds the
// verdict word until it is taken.
// ============================================================================
`include "interval_set_overlap_check_macros.svh"

module isoc_out
    import isoc_pkg::*;
#(
    parameter int MAX_MEETINGS = 64,
    parameter int CW           = 7
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_tok_ctl      i_ctl,
    input  logic [CW-1:0] i_cnt,
    output logic          o_advance,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output t_out_word     o_out_word
);

    logic      r_out_valid;
    t_out_word r_out_word;
    logic      r_conflict;
    logic      r_overflow;
    logic      take;
    logic      emit;

    // Stall the chain only when a finished set meets a full output register that is not being taken
    assign o_advance = !(i_ctl.valid && i_ctl.last && r_out_valid && !i_out_ready);
    assign take      = o_advance && i_ctl.valid;
    assign emit      = take && i_ctl.last;

    // Accumulate per-set flags, clear them at the end of each set
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_conflict  <= 1'b0;
            r_overflow  <= 1'b0;
        end else begin
            if (emit) begin
                r_out_valid <= 1'b1;
                r_conflict  <= 1'b0;
                r_overflow  <= 1'b0;
            end else begin
                if (i_out_ready) begin
                    r_out_valid <= 1'b0;
                end
                if (take) begin
                    r_conflict <= r_conflict | i_ctl.hit;
                    r_overflow <= r_overflow | i_ctl.drop;
                end
            end
        end
    end

    // Load the verdict word
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_word.all_compatible <= !(r_conflict | i_ctl.hit);
            r_out_word.set_overflow   <= r_overflow | i_ctl.drop;
            r_out_word.meeting_count  <= COUNT_FIELD_W'(i_cnt);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // An overflowed set reports a full store
    `ISOC_ASSERT_IMP(a_ovf_full, i_clk, i_rst_n, r_out_valid && r_out_word.set_overflow, r_out_word.meeting_count == COUNT_FIELD_W'(MAX_MEETINGS), "overflowed set without full count")

endmodule

[verif/tb_interval_set_overlap_check.sv]
`timescale 1ns / 1ps
// ============================================================================
// tb_interval_set_overlap_check
// Self-checking bench for the interval set overlap checker.
// ============================================================================
// Intervals go in over a valid/ready channel, one word per handshake. A
// predictor in the bench keeps its own copy of the set store and queues one
// expected verdict for every word that closes a set. Each verdict word that
// leaves the block is compared field by field against the oldest queued
// verdict. The stimulus covers these cases:
// - directed sets: touching, contained, empty and inverted intervals
// - sets that fill the store exactly and sets that overflow it
// - a long output stall
// - random sets, mostly disjoint with an occasional clash, plus noise
// ============================================================================
module tb_interval_set_overlap_check;
    import isoc_pkg::*;

    localparam int MAX_MEETINGS = 64;
    localparam int TIME_BITS    = 16;
    localparam int PLAN_DEPTH   = 80;
    localparam int ITEM_TARGET  = 1650;
    localparam int DRAIN_CYCLES = MAX_MEETINGS + 20;
    localparam int LONG_HOLD    = 600;
    localparam int CYCLE_LIMIT  = 900000;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_word  i_in_word   = '0;
    logic      i_out_ready = 1'b0;
    logic      o_in_ready;
    logic      o_out_valid;
    t_out_word o_out_word;

    // Predictor copy of the set store
    logic [TIME_FIELD_W-1:0] held_starts [MAX_MEETINGS];
    logic [TIME_FIELD_W-1:0] held_ends   [MAX_MEETINGS];
    int                      held_count = 0;
    bit                      held_clash = 1'b0;
    bit                      held_spill = 1'b0;
    t_out_word               verdict_q[$];

    // Interval plan for the next set
    logic [TIME_FIELD_W-1:0] plan_start [PLAN_DEPTH];
    logic [TIME_FIELD_W-1:0] plan_end   [PLAN_DEPTH];

    bit no_idle         = 1'b0;
    int rx_hold_req     = 0;
    int error_count     = 0;
    int items_sent      = 0;
    int verdicts_seen   = 0;
    int clash_verdicts  = 0;
    int spill_verdicts  = 0;
    int cycle_count     = 0;

    interval_set_overlap_check #(
        .MAX_MEETINGS (MAX_MEETINGS),
        .TIME_BITS    (TIME_BITS)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

    always #10 i_clk = ~i_clk;

    // Abort a run that hangs
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d verdicts outstanding",
                     $time, cycle_count, verdict_q.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    // Mostly short gaps, a few long ones, none while idling is switched off
    function automatic int idle_len();
        int r;
        r = $urandom_range(99);
        if (no_idle || r < 60) return 0;
        if (r < 88) return $urandom_range(3, 1);
        if (r < 97) return $urandom_range(10, 4);
        return $urandom_range(60, 20);
    endfunction

    // Update the predicted store with one accepted interval
    task automatic track_interval(input t_in_word w);
        t_out_word v;
        items_sent++;
        if (held_count < MAX_MEETINGS) begin
            for (int k = 0; k < held_count; k++) begin
                if (w.start_time < held_ends[k] && held_starts[k] < w.end_time)
                    held_clash = 1'b1;
            end
            held_starts[held_count] = w.start_time;
            held_ends[held_count]   = w.end_time;
            held_count++;
        end else begin
            held_spill = 1'b1;
        end
        if (w.last_meeting) begin
            v.all_compatible = !held_clash;
            v.set_overflow   = held_spill;
            v.meeting_count  = COUNT_FIELD_W'(held_count);
            verdict_q.push_back(v);
            held_count = 0;
            held_clash = 1'b0;
            held_spill = 1'b0;
        end
    endtask

    // Offer one word and hold it until accepted
    task automatic send_word(input t_in_word w);
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        track_interval(w);
    endtask

    task automatic pause_sender(input int n);
        if (n > 0) begin
            i_in_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // Stop sending until every queued verdict has come out
    task automatic wait_verdicts();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (verdict_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic send_iv(input int s, input int e, input bit is_end);
        t_in_word w;
        w.start_time   = TIME_FIELD_W'(s);
        w.end_time     = TIME_FIELD_W'(e);
        w.last_meeting = is_end;
        pause_sender(idle_len());
        send_word(w);
    endtask

    task automatic send_planned(input int n);
        for (int i = 0; i < n; i++) begin
            send_iv(plan_start[i], plan_end[i], i == n - 1);
        end
    endtask

    // Plan n disjoint intervals in ascending order, some of them touching
    task automatic plan_disjoint(input int n);
        int budget;
        int cursor;
        int gap;
        int span;
        budget = 65536 / n;
        cursor = $urandom_range(budget / 4);
        for (int i = 0; i < n; i++) begin
            gap  = ($urandom_range(3) == 0) ? 0 : $urandom_range(budget / 4);
            span = $urandom_range(budget / 2);
            plan_start[i] = TIME_FIELD_W'(cursor + gap);
            plan_end[i]   = TIME_FIELD_W'(cursor + gap + span);
            cursor        = cursor + gap + span;
        end
    endtask

    // Copy one interval over another, widened by one, to force a clash
    task automatic plan_clash(input int n);
        int j;
        int k;
        j = $urandom_range(n - 1);
        k = (j + $urandom_range(n - 1, 1)) % n;
        plan_start[j] = plan_start[k];
        plan_end[j]   = (plan_end[k] == '1) ? plan_end[k] : plan_end[k] + 1'b1;
    endtask

    task automatic plan_shuffle(input int n);
        int j;
        logic [TIME_FIELD_W-1:0] ts;
        logic [TIME_FIELD_W-1:0] te;
        for (int i = n - 1; i > 0; i--) begin
            j  = $urandom_range(i);
            ts = plan_start[i];
            te = plan_end[i];
            plan_start[i] = plan_start[j];
            plan_end[i]   = plan_end[j];
            plan_start[j] = ts;
            plan_end[j]   = te;
        end
    endtask

    // Unordered intervals: full range or a narrow window where edges collide
    task automatic plan_noise(input int n);
        int base;
        bit narrow;
        narrow = $urandom_range(1);
        base   = $urandom_range(65535 - 32);
        for (int i = 0; i < n; i++) begin
            if (narrow) begin
                plan_start[i] = TIME_FIELD_W'(base + $urandom_range(31));
                plan_end[i]   = TIME_FIELD_W'(base + $urandom_range(31));
            end else begin
                plan_start[i] = TIME_FIELD_W'($urandom_range(65535));
                plan_end[i]   = TIME_FIELD_W'($urandom_range(65535));
            end
        end
    endtask

    // Compare each verdict word with the oldest prediction
    always @(posedge i_clk) begin : check_verdicts
        t_out_word want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (verdict_q.size() == 0) begin
                $display("%0t: unexpected verdict word, expected none, got %h",
                         $time, o_out_word);
                error_count++;
            end else begin
                want = verdict_q.pop_front();
                verdicts_seen++;
                if (!want.all_compatible) clash_verdicts++;
                if (want.set_overflow) spill_verdicts++;
                if (o_out_word.all_compatible !== want.all_compatible) begin
                    $display("%0t: all_compatible mismatch, expected %0d, got %0d",
                             $time, want.all_compatible, o_out_word.all_compatible);
                    error_count++;
                end
                if (o_out_word.set_overflow !== want.set_overflow) begin
                    $display("%0t: set_overflow mismatch, expected %0d, got %0d",
                             $time, want.set_overflow, o_out_word.set_overflow);
                    error_count++;
                end
                if (o_out_word.meeting_count !== want.meeting_count) begin
                    $display("%0t: meeting_count mismatch, expected %0d, got %0d",
                             $time, want.meeting_count, o_out_word.meeting_count);
                    error_count++;
                end
            end
        end
    end

    // Drive output ready: random stalls, or a long hold when one is requested
    initial begin : drive_sink
        int stall;
        forever begin
            @(posedge i_clk);
            if (rx_hold_req > 0) begin
                stall       = rx_hold_req;
                rx_hold_req = 0;
            end else begin
                stall = idle_len();
            end
            if (stall == 0) begin
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
                i_out_ready <= 1'b1;
            end
        end
    end

    // Touching, contained, empty, inverted and extreme intervals
    task automatic test_directed_cases();
        send_iv(0, 65535, 1'b1);
        send_iv(10, 20, 1'b0);
        send_iv(20, 30, 1'b0);
        send_iv(0, 10, 1'b1);
        send_iv(100, 200, 1'b0);
        send_iv(150, 160, 1'b1);
        send_iv(150, 160, 1'b0);
        send_iv(100, 200, 1'b1);
        send_iv(100, 200, 1'b0);
        send_iv(150, 150, 1'b0);
        send_iv(200, 200, 1'b1);
        send_iv(300, 300, 1'b0);
        send_iv(300, 400, 1'b0);
        send_iv(400, 400, 1'b1);
        send_iv(500, 400, 1'b0);
        send_iv(450, 460, 1'b0);
        send_iv(0, 65535, 1'b1);
        send_iv(65535, 65535, 1'b0);
        send_iv(65535, 0, 1'b0);
        send_iv(0, 0, 1'b1);
        send_iv(16'hAAAA, 16'h5555, 1'b0);
        send_iv(16'h5555, 16'hAAAA, 1'b1);
        wait_verdicts();
    endtask

    // Fill the store exactly, then spill past it
    task automatic test_full_store();
        plan_disjoint(MAX_MEETINGS);
        plan_shuffle(MAX_MEETINGS);
        send_planned(MAX_MEETINGS);
        // dropped last word would clash if it were compared
        plan_disjoint(MAX_MEETINGS);
        plan_shuffle(MAX_MEETINGS);
        plan_start[MAX_MEETINGS] = plan_start[0];
        plan_end[MAX_MEETINGS]   = plan_end[0] + 1'b1;
        send_planned(MAX_MEETINGS + 1);
        // clash inside the store plus several dropped words
        plan_disjoint(MAX_MEETINGS + 4);
        plan_start[10] = plan_start[3];
        plan_end[10]   = plan_end[3] + 1'b1;
        send_planned(MAX_MEETINGS + 4);
        wait_verdicts();
    endtask

    // Hold the output off while short sets keep streaming in
    task automatic test_output_backpressure();
        int n;
        no_idle     = 1'b1;
        rx_hold_req = LONG_HOLD;
        for (int s = 0; s < 60; s++) begin
            n = $urandom_range(2, 1);
            plan_noise(n);
            send_planned(n);
        end
        no_idle = 1'b0;
        wait_verdicts();
    endtask

    // Random sets, mostly small and well formed
    task automatic test_random_sets();
        int n;
        int r;
        int sets;
        sets = 0;
        while (items_sent < ITEM_TARGET) begin
            r = $urandom_range(99);
            if (r < 80) n = $urandom_range(8, 1);
            else if (r < 95) n = $urandom_range(40, 9);
            else n = $urandom_range(72, 41);
            if ($urandom_range(19) == 0) no_idle = !no_idle;
            if ($urandom_range(99) < 70) begin
                plan_disjoint(n);
                if (n > 1 && $urandom_range(1) == 1) plan_clash(n);
                plan_shuffle(n);
            end else begin
                plan_noise(n);
            end
            send_planned(n);
            sets++;
            if (sets % 25 == 0) wait_verdicts();
        end
        no_idle = 1'b0;
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_cases();
        test_full_store();
        test_output_backpressure();
        test_random_sets();
        wait_verdicts();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Sent %0d intervals; checked %0d verdicts (%0d with a clash, %0d overflowed).",
                 items_sent, verdicts_seen, clash_verdicts, spill_verdicts);
        $display("Covered touching, contained, empty and inverted intervals, a full store, "
                 , "a spilled store and a long output stall; %0d mismatches.", error_count);
        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
